// ----- rtl/core/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } tcc_state_t;

    typedef enum logic [1:0] {
        OP_NEXT  = 2'd0,
        OP_SET   = 2'd1,
        OP_FLASH = 2'd2,
        OP_READ  = 2'd3
    } tcc_op_t;

    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_MARK  = 8'd95;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_BS    = 8'd8;

    localparam logic [1:0] GEO_40X25 = 2'd0;
    localparam logic [1:0] GEO_80X25 = 2'd1;
    localparam logic [1:0] GEO_80X43 = 2'd2;
    localparam logic [1:0] GEO_80X50 = 2'd3;

    // Rows of a geometry before limiting to the built store
    function automatic logic [6:0] geo_rows(input logic [1:0] geo);
        logic [6:0] r;
        unique case (geo)
            GEO_40X25: r = 7'd25;
            GEO_80X25: r = 7'd25;
            GEO_80X43: r = 7'd43;
            GEO_80X50: r = 7'd50;
            default:   r = 7'd25;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] geo_cols(input logic [1:0] geo);
        logic [7:0] c;
        unique case (geo)
            GEO_40X25: c = 8'd40;
            GEO_80X25: c = 8'd80;
            GEO_80X43: c = 8'd80;
            GEO_80X50: c = 8'd80;
            default:   c = 8'd40;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcc_store.sv -----
`default_nettype none

module tcc_store
    import tcc_pkg::*;
#(
    parameter int DEPTH  = 4000,
    parameter int ADDR_W = 12
)(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_cursor_buffer.sv -----
// Channel   | Signals                                              | Handshake
// ----------+------------------------------------------------------+--------------------------
// command   | start, busy, mode, char_code, row, col               | taken when start && !busy
// result    | done, cell_char, caret_row, caret_col, cursor_shown  | one-cycle strobe on done
// config    | cfg_valid, cfg_ready, text_mode                      | taken when valid && ready
//
// The cycle after acceptance does the first store access, the next one
// presents the result on done and does the second blank of a backspace.
// busy is low in that result cycle, so a new item can be accepted then.
// After reset and after every text_mode write a clearing pass over all
// MAX_ROWS*MAX_COLS cells (4000 by default) fills the store with spaces with
// busy high. cfg_ready is low while an item executes, and outside the clearing
// pass while start is offered. The receiver cannot stall; done is not held.
`default_nettype none

module text_console_cursor_buffer
    import tcc_pkg::*;
#(
    parameter int MAX_ROWS = 50,
    parameter int MAX_COLS = 80
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] char_code,
    input  wire logic [5:0] row,
    input  wire logic [6:0] col,
    output logic            done,
    output logic      [7:0] cell_char,
    output logic      [5:0] caret_row,
    output logic      [6:0] caret_col,
    output logic            cursor_shown,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] text_mode
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    tcc_state_t state_reg, state_next;

    logic [1:0]        text_mode_reg;
    logic [5:0]        cur_row_reg, cur_row_next;
    logic [6:0]        cur_col_reg, cur_col_next;
    logic              phase_reg, phase_next;
    logic [ADDR_W-1:0] clr_cnt_reg;

    tcc_op_t           op_reg;
    logic [7:0]        code_reg;
    logic [5:0]        row_reg;
    logic [6:0]        col_reg;
    logic              bs_reg, bs_next;
    logic              rd_ok_reg, rd_ok_next;

    logic              accept;
    logic              cfg_fire;
    logic              clr_last;

    logic [6:0]        rows_lim;
    logic [7:0]        cols_lim;
    logic [6:0]        row_inc;
    logic [7:0]        col_inc;
    logic [5:0]        row_fwd;
    logic              tgt_ok;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] tgt_addr;
    logic [ADDR_W-1:0] exec_addr;
    logic              exec_we;
    logic [7:0]        exec_data;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    assign accept   = start && !busy;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // Limit the geometry to the built store
    always_comb
    begin
        rows_lim = (geo_rows(text_mode_reg) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS)
                                                             : geo_rows(text_mode_reg);
        cols_lim = (geo_cols(text_mode_reg) > 8'(MAX_COLS)) ? 8'(MAX_COLS)
                                                             : geo_cols(text_mode_reg);
    end

    assign cur_addr = ADDR_W'(cur_row_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(cur_col_reg);
    assign tgt_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(col_reg);
    assign tgt_ok   = ({1'b0, row_reg} < rows_lim) && ({1'b0, col_reg} < cols_lim);

    assign row_inc = {1'b0, cur_row_reg} + 7'd1;
    assign col_inc = {1'b0, cur_col_reg} + 8'd1;
    assign row_fwd = (row_inc >= rows_lim) ? 6'd0 : row_inc[5:0];

    // First store access and cursor move of the item
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        phase_next   = phase_reg;
        bs_next      = 1'b0;
        rd_ok_next   = 1'b0;
        exec_addr    = cur_addr;
        exec_we      = 1'b0;
        exec_data    = CODE_SPACE;
        unique case (op_reg)
            OP_NEXT:
            begin
                exec_we = 1'b1;
                if (code_reg == CODE_CR)
                begin
                    cur_col_next = 7'd0;
                    cur_row_next = row_fwd;
                end
                else if (code_reg == CODE_BS)
                begin
                    bs_next = 1'b1;
                    if (cur_col_reg == 7'd0)
                    begin
                        cur_col_next = 7'(cols_lim - 8'd1);
                        cur_row_next = (cur_row_reg == 6'd0) ? 6'(rows_lim - 7'd1)
                                                             : cur_row_reg - 6'd1;
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg - 7'd1;
                    end
                end
                else
                begin
                    exec_data = code_reg;
                    if (col_inc >= cols_lim)
                    begin
                        cur_col_next = 7'd0;
                        cur_row_next = row_fwd;
                    end
                    else
                    begin
                        cur_col_next = col_inc[6:0];
                    end
                end
            end
            OP_SET:
            begin
                exec_addr = tgt_addr;
                exec_we   = tgt_ok;
                exec_data = code_reg;
            end
            OP_FLASH:
            begin
                exec_we    = 1'b1;
                exec_data  = phase_reg ? CODE_SPACE : CODE_MARK;
                phase_next = !phase_reg;
            end
            OP_READ:
            begin
                exec_addr  = tgt_addr;
                rd_ok_next = tgt_ok;
            end
            default:
            begin
                exec_we = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cfg_fire)
                    state_next = ST_CLEAR;
                else if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cfg_fire)
                    state_next = ST_CLEAR;
                else if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (cfg_fire)
                    state_next = ST_CLEAR;
                else if (start)
                    state_next = ST_EXEC;
                else
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and store port
    always_comb
    begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        done      = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = cur_addr;
        wr_data   = CODE_SPACE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                busy    = 1'b1;
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                // hold off a geometry write while a command word is offered
                busy      = 1'b0;
                cfg_ready = !start;
            end
            ST_EXEC:
            begin
                busy      = 1'b1;
                cfg_ready = 1'b0;
                wr_en     = exec_we;
                wr_addr   = exec_addr;
                wr_data   = exec_data;
            end
            ST_FINISH:
            begin
                // blank the cell a backspace stepped onto
                done      = 1'b1;
                cfg_ready = !start;
                wr_en     = bs_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign cell_char    = (done && rd_ok_reg) ? rd_data : 8'd0;
    assign caret_row    = cur_row_reg;
    assign caret_col    = cur_col_reg;
    assign cursor_shown = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            text_mode_reg <= GEO_40X25;
            cur_row_reg   <= 6'd0;
            cur_col_reg   <= 7'd0;
            phase_reg     <= 1'b0;
            clr_cnt_reg   <= '0;
            bs_reg        <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                text_mode_reg <= text_mode;
                cur_row_reg   <= 6'd0;
                cur_col_reg   <= 7'd0;
                phase_reg     <= 1'b0;
                clr_cnt_reg   <= '0;
                bs_reg        <= 1'b0;
                rd_ok_reg     <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_CLEAR)
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                end
                if (state_reg == ST_EXEC)
                begin
                    cur_row_reg <= cur_row_next;
                    cur_col_reg <= cur_col_next;
                    phase_reg   <= phase_next;
                    bs_reg      <= bs_next;
                    rd_ok_reg   <= rd_ok_next;
                end
            end
        end
    end

    // Hold the command word for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= tcc_op_t'(mode);
            code_reg <= char_code;
            row_reg  <= row;
            col_reg  <= col;
        end
    end

    tcc_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (exec_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ----- sim/text_console_cursor_buffer_test.sv -----
`timescale 1ns / 1ps

module text_console_cursor_buffer_test;
    import tcc_pkg::*;

    localparam int MAX_ROWS   = 50;
    localparam int MAX_COLS   = 80;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] chr;
        logic [5:0] crow;
        logic [6:0] ccol;
        logic       shown;
    } cursor_report_t;

    class console_tracker;
        logic [7:0]     cells [MAX_ROWS * MAX_COLS];
        logic [1:0]     geometry;
        int             cur_row;
        int             cur_col;
        logic           phase;
        int             errors;
        cursor_report_t waiting [$];

        function new();
            errors = 0;
            reset_screen(GEO_40X25);
        endfunction

        function int rows();
            int n;
            case (geometry)
                GEO_80X43: n = 43;
                GEO_80X50: n = 50;
                default:   n = 25;
            endcase
            return (n > MAX_ROWS) ? MAX_ROWS : n;
        endfunction

        function int cols();
            int n;
            n = (geometry == GEO_40X25) ? 40 : 80;
            return (n > MAX_COLS) ? MAX_COLS : n;
        endfunction

        function void reset_screen(logic [1:0] geo);
            geometry = geo;
            foreach (cells[i])
                cells[i] = CODE_SPACE;
            cur_row = 0;
            cur_col = 0;
            phase   = 1'b0;
        endfunction

        function void poke(int r, int c, logic [7:0] code);
            if (r < rows() && c < cols())
                cells[r * cols() + c] = code;
        endfunction

        function logic [7:0] peek(int r, int c);
            if (r < rows() && c < cols())
                return cells[r * cols() + c];
            return 8'd0;
        endfunction

        function void row_down();
            cur_row = (cur_row + 1 >= rows()) ? 0 : cur_row + 1;
        endfunction

        function void note_command(tcc_op_t op, logic [7:0] code, logic [5:0] r,
                                   logic [6:0] c);
            cursor_report_t rep;
            rep.chr = 8'd0;
            case (op)
                OP_NEXT:
                begin
                    if (code == CODE_CR)
                    begin
                        poke(cur_row, cur_col, CODE_SPACE);
                        cur_col = 0;
                        row_down();
                    end
                    else if (code == CODE_BS)
                    begin
                        poke(cur_row, cur_col, CODE_SPACE);
                        if (cur_col == 0)
                        begin
                            cur_col = cols() - 1;
                            cur_row = (cur_row == 0) ? rows() - 1 : cur_row - 1;
                        end
                        else
                            cur_col--;
                        poke(cur_row, cur_col, CODE_SPACE);
                    end
                    else
                    begin
                        poke(cur_row, cur_col, code);
                        cur_col++;
                        if (cur_col >= cols())
                        begin
                            cur_col = 0;
                            row_down();
                        end
                    end
                end
                OP_SET:
                    poke(int'(r), int'(c), code);
                OP_FLASH:
                begin
                    poke(cur_row, cur_col, phase ? CODE_SPACE : CODE_MARK);
                    phase = ~phase;
                end
                default:
                    rep.chr = peek(int'(r), int'(c));
            endcase
            rep.crow  = 6'(cur_row);
            rep.ccol  = 7'(cur_col);
            rep.shown = phase;
            waiting.push_back(rep);
        endfunction

        function void check_report(logic [7:0] chr, logic [5:0] crow, logic [6:0] ccol,
                                   logic shown);
            cursor_report_t want;
            if (waiting.size() == 0)
            begin
                $error("result with no command pending: cell_char %0d row %0d col %0d",
                       chr, crow, ccol);
                errors++;
                return;
            end
            want = waiting.pop_front();
            if (chr !== want.chr)
            begin
                $error("cell_char: expected %0d, got %0d", want.chr, chr);
                errors++;
            end
            if (crow !== want.crow)
            begin
                $error("caret_row: expected %0d, got %0d", want.crow, crow);
                errors++;
            end
            if (ccol !== want.ccol)
            begin
                $error("caret_col: expected %0d, got %0d", want.ccol, ccol);
                errors++;
            end
            if (shown !== want.shown)
            begin
                $error("cursor_shown: expected %0d, got %0d", want.shown, shown);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [1:0] mode      = OP_NEXT;
    logic [7:0] char_code = 8'd0;
    logic [5:0] row       = 6'd0;
    logic [6:0] col       = 7'd0;
    logic       cfg_valid = 1'b0;
    logic [1:0] text_mode = GEO_40X25;
    logic       busy;
    logic       done;
    logic [7:0] cell_char;
    logic [5:0] caret_row;
    logic [6:0] caret_col;
    logic       cursor_shown;
    logic       cfg_ready;

    console_tracker tracker = new();

    bit start_high  = 1'b0;
    int burst_left  = 0;
    int idle_cycles = 0;

    text_console_cursor_buffer #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .char_code   (char_code),
        .row         (row),
        .col         (col),
        .done        (done),
        .cell_char   (cell_char),
        .caret_row   (caret_row),
        .caret_col   (caret_col),
        .cursor_shown(cursor_shown),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .text_mode   (text_mode)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_report(cell_char, caret_row, caret_col, cursor_shown);
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (cfg_valid && cfg_ready) || (start && !busy))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("text_console_cursor_buffer_test: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic issue_command(tcc_op_t op, logic [7:0] code, logic [5:0] r, logic [6:0] c);
        start      <= 1'b1;
        mode       <= op;
        char_code  <= code;
        row        <= r;
        col        <= c;
        start_high = 1'b1;
        do
            @(posedge clk);
        while (busy);
        tracker.note_command(op, code, r, c);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // end the burst: drop start for a random gap
            start      <= 1'b0;
            start_high = 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic drain_results();
        if (start_high)
        begin
            start      <= 1'b0;
            start_high = 1'b0;
        end
        do
            @(negedge clk);
        while (tracker.waiting.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_geometry(logic [1:0] geo);
        drain_results();
        cfg_valid <= 1'b1;
        text_mode <= geo;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.reset_screen(geo);
        cfg_valid <= 1'b0;
    endtask

    task automatic type_random(int count, int next_pct, int cr_pct, int bs_pct);
        int         pick;
        tcc_op_t    op;
        logic [7:0] code;
        logic [5:0] r;
        logic [6:0] c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(0, 255));
            r    = 6'($urandom_range(0, 63));
            c    = 7'($urandom_range(0, 127));
            if (pick < next_pct)
            begin
                op   = OP_NEXT;
                pick = $urandom_range(0, 99);
                if (pick < cr_pct)
                    code = CODE_CR;
                else if (pick < cr_pct + bs_pct)
                    code = CODE_BS;
            end
            else if (pick < next_pct + (100 - next_pct) * 3 / 10)
            begin
                op = OP_SET;
                if ($urandom_range(0, 4) != 0)
                begin
                    r = 6'($urandom_range(0, tracker.rows() - 1));
                    c = 7'($urandom_range(0, tracker.cols() - 1));
                end
            end
            else if (pick < next_pct + (100 - next_pct) * 5 / 10)
                op = OP_FLASH;
            else
            begin
                op   = OP_READ;
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // look at or just behind the cursor, where typing landed
                    r = 6'(tracker.cur_row);
                    c = 7'((tracker.cur_col == 0) ? 0
                                                  : tracker.cur_col - $urandom_range(0, 1));
                end
                else if (pick < 85)
                begin
                    r = 6'($urandom_range(0, tracker.rows() - 1));
                    c = 7'($urandom_range(0, tracker.cols() - 1));
                end
            end
            issue_command(op, code, r, c);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = 4;

        // 40x25 after reset: wraps at the screen corners, flash, range checks
        issue_command(OP_READ,  8'd0,      6'd0,  7'd0);
        issue_command(OP_NEXT,  CODE_BS,   6'd0,  7'd0);
        issue_command(OP_NEXT,  CODE_CR,   6'd63, 7'd127);
        issue_command(OP_NEXT,  8'd65,     6'd0,  7'd0);
        issue_command(OP_NEXT,  8'd255,    6'd0,  7'd0);
        issue_command(OP_NEXT,  8'd0,      6'd0,  7'd0);
        issue_command(OP_FLASH, 8'd0,      6'd0,  7'd0);
        issue_command(OP_FLASH, 8'd255,    6'd63, 7'd127);
        issue_command(OP_FLASH, 8'd0,      6'd0,  7'd0);
        issue_command(OP_NEXT,  8'd120,    6'd0,  7'd0);
        issue_command(OP_NEXT,  CODE_BS,   6'd0,  7'd0);
        issue_command(OP_SET,   8'd127,    6'd24, 7'd39);
        issue_command(OP_SET,   8'd1,      6'd25, 7'd0);
        issue_command(OP_SET,   8'd2,      6'd0,  7'd40);
        issue_command(OP_SET,   8'd255,    6'd63, 7'd127);
        issue_command(OP_READ,  8'd0,      6'd24, 7'd39);
        issue_command(OP_READ,  8'd0,      6'd63, 7'd127);
        issue_command(OP_READ,  8'd0,      6'd0,  7'd40);
        issue_command(OP_READ,  8'd0,      6'd0,  7'd0);
        issue_command(OP_READ,  8'd0,      6'd0,  7'd3);
        type_random(250, 60, 30, 10);

        write_geometry(GEO_80X50);
        issue_command(OP_NEXT,  CODE_BS,   6'd0,  7'd0);
        issue_command(OP_SET,   8'd200,    6'd49, 7'd79);
        issue_command(OP_READ,  8'd0,      6'd49, 7'd79);
        issue_command(OP_READ,  8'd0,      6'd50, 7'd0);
        issue_command(OP_READ,  8'd0,      6'd49, 7'd80);
        issue_command(OP_NEXT,  CODE_CR,   6'd0,  7'd0);
        type_random(250, 50, 3, 5);

        write_geometry(GEO_80X25);
        type_random(250, 70, 25, 8);

        write_geometry(GEO_80X43);
        type_random(250, 50, 20, 10);

        write_geometry(GEO_40X25);
        type_random(200, 85, 1, 1);

        drain_results();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("text_console_cursor_buffer_test: clean");
        else
            $display("text_console_cursor_buffer_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tcc_pkg.sv
rtl/core/tcc_store.sv
rtl/core/text_console_cursor_buffer.sv
sim/text_console_cursor_buffer_test.sv
